[hw/rtl/bop_pkg.sv]
package bop_pkg;

    localparam int RR_ENTRIES   = 256;
    localparam int BLOCK_BYTES  = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int OFFSET_COUNT = 52;

    localparam int LIST_LEN    = 52;
    localparam int ADDR_W      = 48;
    localparam int TAG_W       = 12;
    localparam int TAG_SHIFT   = 8;
    localparam int SCORE_W     = 6;
    localparam int ROUND_W     = 9;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int OFF_W       = 9;

    localparam int RR_AW       = $clog2(RR_ENTRIES);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int SCORE_AW    = (OFFSET_COUNT > 1) ? $clog2(OFFSET_COUNT) : 1;
    localparam int CNT_W       = $clog2(OFFSET_COUNT + 1);

    localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_SCORE = 2'd2;

    localparam logic [OFF_W-1:0] OFFSET_LIST [LIST_LEN] = '{
        9'd1,   9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd8,   9'd9,   9'd10,
        9'd12,  9'd15,  9'd16,  9'd18,  9'd20,  9'd24,  9'd25,  9'd27,  9'd30,
        9'd32,  9'd36,  9'd40,  9'd45,  9'd48,  9'd50,  9'd54,  9'd60,  9'd64,
        9'd72,  9'd75,  9'd80,  9'd81,  9'd90,  9'd96,  9'd100, 9'd108, 9'd120,
        9'd125, 9'd128, 9'd135, 9'd144, 9'd150, 9'd160, 9'd162, 9'd180, 9'd192,
        9'd200, 9'd216, 9'd225, 9'd240, 9'd243, 9'd250, 9'd256
    };

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] line_addr;
        logic              fill_was_prefetched;
    } req_t;

    typedef struct packed {
        logic              prefetch_valid;
        logic [ADDR_W-1:0] prefetch_addr;
    } rsp_t;

    typedef struct packed {
        logic                sub;
        logic                use_off;
        logic [SCORE_AW-1:0] off_idx;
    } alu_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic [RR_AW-1:0]  rr_idx;
        logic [TAG_W-1:0]  tag;
        logic              same_page;
    } alu_rsp_t;

    function automatic logic [OFF_W-1:0] offset_blocks(input logic [SCORE_AW-1:0] i);
        logic [OFF_W-1:0] v;
        v = OFFSET_LIST[0];
        if (int'(i) < LIST_LEN)
        begin
            v = OFFSET_LIST[i];
        end
        return v;
    endfunction

endpackage

[hw/rtl/bop_ram.sv]
module bop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/bop_alu.sv]
module bop_alu (
    input  logic [bop_pkg::ADDR_W-1:0] addr,
    input  bop_pkg::alu_req_t          req,
    output bop_pkg::alu_rsp_t          rsp
);

    logic [bop_pkg::ADDR_W-1:0] off_bytes;
    logic [bop_pkg::ADDR_W-1:0] sum;

    always_comb
    begin
        off_bytes = '0;
        if (req.use_off)
        begin
            off_bytes = bop_pkg::ADDR_W'(bop_pkg::offset_blocks(req.off_idx))
                        << bop_pkg::BLOCK_SHIFT;
        end
        sum = req.sub ? (addr - off_bytes) : (addr + off_bytes);

        rsp.sum       = sum;
        rsp.tag       = sum[bop_pkg::TAG_SHIFT +: bop_pkg::TAG_W];
        rsp.rr_idx    = sum[bop_pkg::RR_AW-1:0] ^ sum[bop_pkg::TAG_SHIFT +: bop_pkg::RR_AW];
        rsp.same_page = (sum[bop_pkg::ADDR_W-1:bop_pkg::PAGE_SHIFT]
                         == addr[bop_pkg::ADDR_W-1:bop_pkg::PAGE_SHIFT]);
    end

endmodule

[hw/rtl/best_offset_prefetcher.sv]
// Channel   Dir  Handshake             Payload
// req       in   req_valid/req_ready   bop_pkg::req_t (action, line_addr, fill_was_prefetched)
// rsp       out  rsp_valid/rsp_ready   bop_pkg::rsp_t (prefetch_valid, prefetch_addr)
// cfg       in   cfg_we                cfg_idx, cfg_wdata
//
// From acceptance to the next acceptance, an access request makes one tag RAM lookup per
// offset through the shared address unit, pipelined one offset per cycle. An early win
// cuts the scan short. A fill passes through the fill and finish states without a scan.
// Reset is asynchronous; the recent-request table and the scores use valid bits, so no
// clearing pass is needed. req_ready is low while a request is in work. The result waits
// in the output register, and the next request is accepted meanwhile.
module best_offset_prefetcher (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  bop_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bop_pkg::rsp_t                  rsp,
    input  logic                           cfg_we,
    input  logic [bop_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bop_pkg::CFG_W-1:0]      cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FILL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam int SW  = bop_pkg::SCORE_W;
    localparam int SAW = bop_pkg::SCORE_AW;
    localparam int AW  = bop_pkg::ADDR_W;

    state_t state_reg, state_next;

    logic [SW-1:0]                    score_max_reg;
    logic [bop_pkg::CFG_W-1:0]        round_max_reg;
    logic [SW-1:0]                    bad_score_reg;

    logic [AW-1:0]                    addr_reg, addr_next;
    logic                             fpf_reg, fpf_next;
    logic                             is_access_reg, is_access_next;
    logic [bop_pkg::ROUND_W-1:0]      round_count_reg, round_count_next;
    logic [SAW-1:0]                   best_index_reg, best_index_next;
    logic                             prefetch_on_reg, prefetch_on_next;

    logic [bop_pkg::CNT_W-1:0]        iss_idx_reg, iss_idx_next;
    logic                             chk_valid_reg, chk_valid_next;
    logic [SAW-1:0]                   chk_idx_reg, chk_idx_next;
    logic [bop_pkg::TAG_W-1:0]        chk_tag_reg, chk_tag_next;
    logic [bop_pkg::RR_AW-1:0]        chk_rr_reg, chk_rr_next;
    logic [SW-1:0]                    top_reg, top_next;
    logic [SAW-1:0]                   win_reg, win_next;

    logic [bop_pkg::RR_ENTRIES-1:0]   tag_vld_reg;
    logic [bop_pkg::OFFSET_COUNT-1:0] score_vld_reg;

    logic                             rsp_valid_reg, rsp_valid_next;
    bop_pkg::rsp_t                    rsp_reg, rsp_next;

    bop_pkg::alu_req_t                alu_req;
    bop_pkg::alu_rsp_t                alu_rsp;

    logic                             tag_we;
    logic [bop_pkg::TAG_W-1:0]        tag_rdata;
    logic                             score_we;
    logic [SW-1:0]                    score_rdata;
    logic [SW-1:0]                    new_score;

    logic                             accept;
    logic                             clear_scores;
    logic                             out_free;
    logic                             hit;
    logic [bop_pkg::TAG_W-1:0]        stored_tag;
    logic [SW-1:0]                    cur_score;
    logic                             issue_on;
    logic [bop_pkg::ROUND_W-1:0]      round_inc;
    logic [SW-1:0]                    top_cand;
    logic [SAW-1:0]                   win_cand;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign clear_scores = accept && (req.action == bop_pkg::ACT_ACCESS)
                          && (round_count_reg == '0);

    bop_alu u_alu (
        .addr (addr_reg),
        .req  (alu_req),
        .rsp  (alu_rsp)
    );

    bop_ram #(
        .WIDTH (bop_pkg::TAG_W),
        .DEPTH (bop_pkg::RR_ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (alu_rsp.rr_idx),
        .wdata (alu_rsp.tag),
        .raddr (alu_rsp.rr_idx),
        .rdata (tag_rdata)
    );

    bop_ram #(
        .WIDTH (SW),
        .DEPTH (bop_pkg::OFFSET_COUNT)
    ) u_score_ram (
        .clk   (clk),
        .we    (score_we),
        .waddr (chk_idx_reg),
        .wdata (new_score),
        .raddr (iss_idx_reg[SAW-1:0]),
        .rdata (score_rdata)
    );

    // Shared address unit: base address while scanning or filling, prefetch address at the end.
    always_comb
    begin
        alu_req = '{sub: 1'b0, use_off: 1'b1, off_idx: best_index_reg};
        unique case (state_reg)
            ST_FILL:
            begin
                alu_req = '{sub: 1'b1, use_off: prefetch_on_reg, off_idx: best_index_reg};
            end
            ST_SCAN:
            begin
                alu_req = '{sub: 1'b1, use_off: 1'b1, off_idx: iss_idx_reg[SAW-1:0]};
            end
            ST_IDLE, ST_FIN:
            begin
                alu_req = '{sub: 1'b0, use_off: 1'b1, off_idx: best_index_reg};
            end
            default:
            begin
                alu_req = '{sub: 1'b0, use_off: 1'b1, off_idx: best_index_reg};
            end
        endcase
    end

    // Entries never written read as zero.
    assign stored_tag = tag_vld_reg[chk_rr_reg] ? tag_rdata : '0;
    assign cur_score  = score_vld_reg[chk_idx_reg] ? score_rdata : '0;
    assign hit        = (stored_tag == chk_tag_reg);
    assign new_score  = (hit && (cur_score != bop_pkg::SCORE_TOP)) ? cur_score + SW'(1)
                                                                      : cur_score;
    assign score_we   = (state_reg == ST_SCAN) && chk_valid_reg && hit;
    assign tag_we     = (state_reg == ST_FILL)
                        && (!prefetch_on_reg || (fpf_reg && alu_rsp.same_page));
    assign issue_on   = (iss_idx_reg < bop_pkg::CNT_W'(bop_pkg::OFFSET_COUNT));
    assign round_inc  = round_count_reg + bop_pkg::ROUND_W'(1);

    always_comb
    begin
        top_cand = top_reg;
        win_cand = win_reg;
        if (new_score > top_reg)
        begin
            top_cand = new_score;
            win_cand = chk_idx_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        fpf_next         = fpf_reg;
        is_access_next   = is_access_reg;
        round_count_next = round_count_reg;
        best_index_next  = best_index_reg;
        prefetch_on_next = prefetch_on_reg;
        iss_idx_next     = iss_idx_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        chk_tag_next     = chk_tag_reg;
        chk_rr_next      = chk_rr_reg;
        top_next         = top_reg;
        win_next         = win_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next      = req.line_addr;
                    fpf_next       = req.fill_was_prefetched;
                    is_access_next = (req.action == bop_pkg::ACT_ACCESS);
                    iss_idx_next   = '0;
                    top_next       = '0;
                    win_next       = '0;
                    state_next     = (req.action == bop_pkg::ACT_FILL) ? ST_FILL : ST_SCAN;
                end
            end
            ST_FILL:
            begin
                state_next = ST_FIN;
            end
            ST_SCAN:
            begin
                if (issue_on)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_idx_reg[SAW-1:0];
                    chk_tag_next   = alu_rsp.tag;
                    chk_rr_next    = alu_rsp.rr_idx;
                    iss_idx_next   = iss_idx_reg + bop_pkg::CNT_W'(1);
                end
                if (chk_valid_reg)
                begin
                    top_next = top_cand;
                    win_next = win_cand;
                    if (hit && (new_score >= score_max_reg))
                    begin
                        // Early win: the round ends here and the next access starts afresh.
                        best_index_next  = chk_idx_reg;
                        prefetch_on_next = (new_score > bad_score_reg);
                        round_count_next = '0;
                        chk_valid_next   = 1'b0;
                        state_next       = ST_FIN;
                    end
                    else if (chk_idx_reg == SAW'(bop_pkg::OFFSET_COUNT - 1))
                    begin
                        if (round_inc > bop_pkg::ROUND_W'(round_max_reg))
                        begin
                            round_count_next = '0;
                            best_index_next  = win_cand;
                            prefetch_on_next = (top_cand > bad_score_reg);
                        end
                        else
                        begin
                            round_count_next = round_inc;
                        end
                        chk_valid_next = 1'b0;
                        state_next     = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (is_access_reg && prefetch_on_reg)
                    begin
                        rsp_next.prefetch_valid = 1'b1;
                        rsp_next.prefetch_addr  = alu_rsp.sum;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            score_max_reg   <= SW'(31);
            round_max_reg   <= bop_pkg::CFG_W'(100);
            bad_score_reg   <= SW'(1);
            round_count_reg <= '0;
            best_index_reg  <= '0;
            prefetch_on_reg <= 1'b0;
            iss_idx_reg     <= '0;
            chk_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            tag_vld_reg     <= '0;
            score_vld_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            round_count_reg <= round_count_next;
            best_index_reg  <= best_index_next;
            prefetch_on_reg <= prefetch_on_next;
            iss_idx_reg     <= iss_idx_next;
            chk_valid_reg   <= chk_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_we)
            begin
                if (cfg_idx == bop_pkg::CFG_SCORE_MAX)
                begin
                    score_max_reg <= cfg_wdata[SW-1:0];
                end
                else if (cfg_idx == bop_pkg::CFG_ROUND_MAX)
                begin
                    round_max_reg <= cfg_wdata;
                end
                else if (cfg_idx == bop_pkg::CFG_BAD_SCORE)
                begin
                    bad_score_reg <= cfg_wdata[SW-1:0];
                end
            end
            if (tag_we)
            begin
                tag_vld_reg[alu_rsp.rr_idx] <= 1'b1;
            end
            if (clear_scores)
            begin
                score_vld_reg <= '0;
            end
            else if (score_we)
            begin
                score_vld_reg[chk_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        fpf_reg       <= fpf_next;
        is_access_reg <= is_access_next;
        chk_idx_reg   <= chk_idx_next;
        chk_tag_reg   <= chk_tag_next;
        chk_rr_reg    <= chk_rr_next;
        top_reg       <= top_next;
        win_reg       <= win_next;
        rsp_reg       <= rsp_next;
    end

    a_no_addr_without_prefetch: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.prefetch_valid) |-> (rsp_reg.prefetch_addr == '0))
        else $error("prefetch address not zero on a result without prefetch");

    a_no_tag_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !tag_we)
        else $error("recent-request table written during an offset scan");

    a_score_write_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        score_we |-> (chk_idx_reg != iss_idx_reg[SAW-1:0]) || !issue_on)
        else $error("score read and write collide on one entry");

    a_round_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        clear_scores |=> (score_vld_reg == '0))
        else $error("scores not cleared at the start of a round");

endmodule

[bench/best_offset_prefetcher_tb.sv]
`timescale 1ns / 100ps

module best_offset_prefetcher_tb;

    import bop_pkg::*;

    localparam int DRAIN_CYCLES = 60;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        req_t                   request;
        logic                   no_prefetch;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
    } plan_row_t;

    // Rows marked no_prefetch must return an empty result; every row goes through the predictor.
    localparam plan_row_t PLAN [23] = '{
        '{ROW_REQUEST, '{ACT_FILL,   48'h0000_0000_0000, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_FILL,   48'hFFFF_FFFF_FFFF, 1'b1}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h0000_0000_0040, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'hFFFF_FFFF_FFFF, 1'b1}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h0000_0000_0000, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_WRITE,   '0,                                      1'b0, CFG_SCORE_MAX, 8'd0},
        '{ROW_WRITE,   '0,                                      1'b0, CFG_BAD_SCORE, 8'd0},
        '{ROW_REQUEST, '{ACT_FILL,   48'h0000_0000_1000, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h0000_0000_1040, 1'b0}, 1'b0, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_FILL,   48'h0000_0000_1080, 1'b1}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_FILL,   48'h0000_0000_2000, 1'b1}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_FILL,   48'h0000_0000_3000, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h0000_0000_1080, 1'b0}, 1'b0, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h8000_0000_1040, 1'b1}, 1'b0, CFG_SCORE_MAX, 8'd0},
        '{ROW_WRITE,   '0,                                      1'b0, CFG_ROUND_MAX, 8'd0},
        '{ROW_WRITE,   '0,                                      1'b0, CFG_SCORE_MAX, 8'd63},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h5555_5555_5555, 1'b1}, 1'b0, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'hAAAA_AAAA_AAAA, 1'b0}, 1'b0, CFG_SCORE_MAX, 8'd0},
        '{ROW_WRITE,   '0,                                      1'b0, CFG_BAD_SCORE, 8'd63},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h0000_0000_1040, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_REQUEST, '{ACT_FILL,   48'h0000_0000_1040, 1'b1}, 1'b1, CFG_SCORE_MAX, 8'd0},
        '{ROW_WRITE,   '0,                                      1'b0, CFG_ROUND_MAX, 8'd255},
        '{ROW_REQUEST, '{ACT_ACCESS, 48'h0000_0000_1040, 1'b0}, 1'b1, CFG_SCORE_MAX, 8'd0}
    };

    // Register settings per random phase: score_max, round_max, bad_score.
    // Upper bits beyond a register's width are set in one phase on purpose.
    localparam logic [CFG_W-1:0] PHASE_REGS [7][3] = '{
        '{8'd31, 8'd100, 8'd1},
        '{8'd1,  8'd1,   8'd0},
        '{8'd63, 8'd255, 8'd63},
        '{8'd4,  8'd20,  8'd2},
        '{8'd0,  8'd0,   8'd0},
        '{8'hC8, 8'd12,  8'h43},
        '{8'd16, 8'd40,  8'd5}
    };
    localparam int PHASE_ITEMS = 130;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_wdata;

    // Predictor state.
    logic [TAG_W-1:0]      rr_tags [RR_ENTRIES];
    logic [SCORE_W-1:0]    scores [OFFSET_COUNT];
    logic [ROUND_W-1:0]    round_cnt;
    logic [5:0]            best_idx;
    logic                  pf_on;
    logic [SCORE_W-1:0]    cfg_score_max;
    logic [7:0]            cfg_round_max;
    logic [SCORE_W-1:0]    cfg_bad_score;

    rsp_t                  pending_prefetches [$];
    int                    mismatches;
    int                    idle_limit;

    best_offset_prefetcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [TAG_W-1:0] tag_of(logic [ADDR_W-1:0] a);
        return a[TAG_SHIFT +: TAG_W];
    endfunction

    function automatic logic [RR_AW-1:0] slot_of(logic [ADDR_W-1:0] a);
        return a[RR_AW-1:0] ^ a[TAG_SHIFT +: RR_AW];
    endfunction

    function automatic logic [ADDR_W-1:0] stride_bytes(logic [5:0] i);
        return ADDR_W'(OFFSET_LIST[i]) << BLOCK_SHIFT;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Advances the predictor by one request and returns the result it should produce.
    function automatic rsp_t next_prefetch(req_t r);
        rsp_t              res;
        logic [ADDR_W-1:0] base;
        logic [SCORE_W-1:0] top;
        bit                stopped;
        int                k;
        res = '0;
        if (r.action == ACT_FILL)
        begin
            if (!pf_on)
            begin
                rr_tags[slot_of(r.line_addr)] = tag_of(r.line_addr);
            end
            else if (r.fill_was_prefetched)
            begin
                base = r.line_addr - stride_bytes(best_idx);
                if (base[ADDR_W-1:PAGE_SHIFT] == r.line_addr[ADDR_W-1:PAGE_SHIFT])
                begin
                    rr_tags[slot_of(base)] = tag_of(base);
                end
            end
        end
        else
        begin
            if (round_cnt == '0)
            begin
                foreach (scores[j])
                begin
                    scores[j] = '0;
                end
            end
            stopped = 1'b0;
            for (k = 0; k < OFFSET_COUNT && !stopped; k++)
            begin
                base = r.line_addr - stride_bytes(6'(k));
                if (rr_tags[slot_of(base)] == tag_of(base))
                begin
                    if (scores[k] != SCORE_TOP)
                    begin
                        scores[k] = scores[k] + 1'b1;
                    end
                    // Reaching the threshold ends the round on this very access.
                    if (scores[k] >= cfg_score_max)
                    begin
                        best_idx  = 6'(k);
                        pf_on     = scores[k] > cfg_bad_score;
                        round_cnt = '0;
                        stopped   = 1'b1;
                    end
                end
            end
            if (!stopped)
            begin
                round_cnt = round_cnt + 1'b1;
                if (round_cnt > ROUND_W'(cfg_round_max))
                begin
                    round_cnt = '0;
                    top       = '0;
                    best_idx  = '0;
                    for (k = 0; k < OFFSET_COUNT; k++)
                    begin
                        if (scores[k] > top)
                        begin
                            top      = scores[k];
                            best_idx = 6'(k);
                        end
                    end
                    pf_on = top > cfg_bad_score;
                end
            end
            if (pf_on)
            begin
                res.prefetch_valid = 1'b1;
                res.prefetch_addr  = r.line_addr + stride_bytes(best_idx);
            end
        end
        return res;
    endfunction

    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic send_request(input req_t r, input bit no_prefetch, output rsp_t predicted);
        int gap;
        gap = $urandom_range(0, idle_limit);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = next_prefetch(r);
        pending_prefetches.insert(pending_prefetches.size(),
                                  no_prefetch ? rsp_t'('0) : predicted);
    endtask

    // Stops sending and waits for every outstanding result; always moves at least one edge.
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_prefetches.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_idx   <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCORE_MAX: cfg_score_max = val[SCORE_W-1:0];
            CFG_ROUND_MAX: cfg_round_max = val[7:0];
            CFG_BAD_SCORE: cfg_bad_score = val[SCORE_W-1:0];
            default: ;
        endcase
        // A quiet edge follows, so that a following write starts in a fresh time step.
        @(posedge clk);
    endtask

    // Mostly a strided access stream with the matching fills, so that scores build up and
    // prefetching turns on; the rest is unrelated noise.
    task automatic run_stream(input int n);
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] step;
        req_t              r;
        rsp_t              got;
        int                sent;
        cursor = random_addr();
        step   = stride_bytes(6'($urandom_range(0, OFFSET_COUNT - 1)));
        sent   = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                r.action              = 1'($urandom);
                r.line_addr           = random_addr();
                r.fill_was_prefetched = 1'($urandom);
                send_request(r, 1'b0, got);
                sent++;
            end
            else
            begin
                r.action              = ACT_ACCESS;
                r.line_addr           = cursor;
                r.fill_was_prefetched = 1'($urandom);
                send_request(r, 1'b0, got);
                r.action = ACT_FILL;
                if (got.prefetch_valid)
                begin
                    r.line_addr           = got.prefetch_addr;
                    r.fill_was_prefetched = 1'b1;
                end
                else
                begin
                    r.fill_was_prefetched = ($urandom_range(0, 3) == 0);
                end
                send_request(r, 1'b0, got);
                sent += 2;
                cursor += step;
                if ($urandom_range(0, 39) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: cursor = ADDR_W'($urandom_range(0, 16383));
                        1: cursor = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 16383));
                        default: cursor = random_addr();
                    endcase
                    step = stride_bytes(6'($urandom_range(0, OFFSET_COUNT - 1)));
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                settle();
            end
        end
    endtask

    initial
    begin
        rsp_t want;
        int   stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, idle_limit);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            if (pending_prefetches.size() == 0)
            begin
                $error("unexpected result: prefetch_valid %0b prefetch_addr %h",
                       rsp.prefetch_valid, rsp.prefetch_addr);
                mismatches++;
            end
            else
            begin
                want = pending_prefetches.pop_front();
                if (rsp.prefetch_valid !== want.prefetch_valid)
                begin
                    $error("prefetch_valid: expected %0b, got %0b",
                           want.prefetch_valid, rsp.prefetch_valid);
                    mismatches++;
                end
                if (rsp.prefetch_addr !== want.prefetch_addr)
                begin
                    $error("prefetch_addr: expected %h, got %h",
                           want.prefetch_addr, rsp.prefetch_addr);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rsp_t got;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_wdata  = '0;
        mismatches = 0;
        idle_limit = 12;
        foreach (rr_tags[j])
        begin
            rr_tags[j] = '0;
        end
        foreach (scores[j])
        begin
            scores[j] = '0;
        end
        round_cnt     = '0;
        best_idx      = '0;
        pf_on         = 1'b0;
        cfg_score_max = 6'd31;
        cfg_round_max = 8'd100;
        cfg_bad_score = 6'd1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[k])
        begin
            if (PLAN[k].kind == ROW_WRITE)
            begin
                settle();
                write_reg(PLAN[k].reg_idx, PLAN[k].reg_val);
            end
            else
            begin
                send_request(PLAN[k].request, PLAN[k].no_prefetch, got);
            end
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            write_reg(CFG_SCORE_MAX, PHASE_REGS[ph][0]);
            write_reg(CFG_ROUND_MAX, PHASE_REGS[ph][1]);
            write_reg(CFG_BAD_SCORE, PHASE_REGS[ph][2]);
            // One phase runs back to back on both sides.
            idle_limit = (ph == 3) ? 0 : 12;
            run_stream(PHASE_ITEMS);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
